// File: rtl/ltr_pkg.sv
// shared types and constants of the latest result table
`timescale 1ns / 1ps
package ltr_pkg;

    // largest detection count a publish may carry
    localparam int unsigned MAX_DETECTIONS = 32;

    // request opcodes
    localparam logic [1:0] OPC_PUBLISH    = 2'd0;
    localparam logic [1:0] OPC_READ       = 2'd1;
    localparam logic [1:0] OPC_INVALIDATE = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_STALE     = 2'd1;
    localparam logic [1:0] STATUS_NOT_VALID = 2'd2;
    localparam logic [1:0] STATUS_BAD       = 2'd3;

    // decoded request kind
    typedef enum logic [1:0] {
        KIND_PUBLISH,
        KIND_READ,
        KIND_INVALIDATE,
        KIND_NONE
    } kind_t;

    // classified request as it travels from front to back
    typedef struct packed {
        kind_t       kind;
        logic        bad;
        logic [4:0]  stream;
        logic [31:0] job;
        logic [31:0] frame;
        logic [63:0] stamp;
        logic [7:0]  worker;
        logic [15:0] revision;
        logic [7:0]  detections;
    } cmd_t;

endpackage

// File: rtl/ltr_req_if.sv
// request channel of the latest result table
`timescale 1ns / 1ps
interface ltr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [4:0]  stream;
    logic [31:0] job;
    logic [31:0] frame;
    logic [63:0] stamp;
    logic [7:0]  worker;
    logic [15:0] revision;
    logic [7:0]  detections;

    modport source (
        output valid, opcode, stream, job, frame, stamp, worker, revision, detections,
        input  ready
    );
    modport sink (
        input  valid, opcode, stream, job, frame, stamp, worker, revision, detections,
        output ready
    );
endinterface

// File: rtl/ltr_rsp_if.sv
// result channel of the latest result table
`timescale 1ns / 1ps
interface ltr_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_job;
    logic [31:0] out_frame;
    logic [63:0] out_stamp;
    logic [7:0]  out_worker;
    logic [15:0] out_revision;
    logic [7:0]  out_detections;
    logic [31:0] publish_total;
    logic [31:0] stale_total;
    logic [31:0] error_total;

    modport source (
        output valid, status, out_job, out_frame, out_stamp, out_worker, out_revision,
               out_detections, publish_total, stale_total, error_total,
        input  ready
    );
    modport sink (
        input  valid, status, out_job, out_frame, out_stamp, out_worker, out_revision,
               out_detections, publish_total, stale_total, error_total,
        output ready
    );
endinterface

// File: rtl/latest_result_table.sv
// Latest result table: keeps the newest header record for each stream and three
// wrapping event counters (accepted publishes, stale publishes, bad publishes).
// Every request gives exactly one result. A request is taken in the cycle it is
// offered while the two-entry queue has room; its result passes through a queue
// slot and the result register. The back end retires one request per cycle, so
// with the result side always ready the block sustains one request per clock,
// a figure set by the single read-compare-write of the record table per cycle.
// No clearing pass is needed after reset: stream valid bits clear at once.
`timescale 1ns / 1ps
module latest_result_table #(
    parameter int unsigned STREAM_COUNT = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ltr_req_if.sink   req,
    ltr_rsp_if.source rsp
);

    localparam int unsigned QUEUE_DEPTH = 2;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    ltr_pkg::cmd_t push_cmd;
    ltr_pkg::cmd_t head_cmd;

    // request classification
    ltr_front #(
        .STREAM_COUNT (STREAM_COUNT)
    ) u_front (
        .req      (req),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decoupling queue
    ltr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // table update and result
    ltr_back #(
        .STREAM_COUNT (STREAM_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

// File: rtl/ltr_front.sv
// front end: accepts requests and classifies them
`timescale 1ns / 1ps
module ltr_front #(
    parameter int unsigned STREAM_COUNT = 16
) (
    ltr_req_if.sink        req,
    input  logic           q_full,
    output logic           push,
    output ltr_pkg::cmd_t  push_cmd
);

    logic in_range;
    logic det_over;

    // accept whenever the queue has room
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    // argument checks
    assign in_range = req.stream < 5'(STREAM_COUNT);
    assign det_over = req.detections > 8'(ltr_pkg::MAX_DETECTIONS);

    // decode and pack the request
    always_comb
    begin
        push_cmd.stream     = req.stream;
        push_cmd.job        = req.job;
        push_cmd.frame      = req.frame;
        push_cmd.stamp      = req.stamp;
        push_cmd.worker     = req.worker;
        push_cmd.revision   = req.revision;
        push_cmd.detections = req.detections;
        case (req.opcode)
            ltr_pkg::OPC_PUBLISH:
            begin
                push_cmd.kind = ltr_pkg::KIND_PUBLISH;
                push_cmd.bad  = !in_range || det_over;
            end
            ltr_pkg::OPC_READ:
            begin
                push_cmd.kind = ltr_pkg::KIND_READ;
                push_cmd.bad  = !in_range;
            end
            ltr_pkg::OPC_INVALIDATE:
            begin
                push_cmd.kind = ltr_pkg::KIND_INVALIDATE;
                push_cmd.bad  = !in_range;
            end
            default:
            begin
                push_cmd.kind = ltr_pkg::KIND_NONE;
                push_cmd.bad  = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/ltr_queue.sv
// short queue of classified requests between front and back
`timescale 1ns / 1ps
module ltr_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ltr_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output ltr_pkg::cmd_t  head_cmd,
    output logic           full,
    output logic           empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ltr_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/ltr_back.sv
// back end: record table, event counters and result register
`timescale 1ns / 1ps
module ltr_back #(
    parameter int unsigned STREAM_COUNT = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ltr_pkg::cmd_t  head_cmd,
    input  logic           empty,
    output logic           pop,
    ltr_rsp_if.source      rsp
);

    localparam int unsigned IDX_W = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

    // record table, one entry per stream
    logic [31:0] job_mem      [STREAM_COUNT];
    logic [31:0] frame_mem    [STREAM_COUNT];
    logic [63:0] stamp_mem    [STREAM_COUNT];
    logic [7:0]  worker_mem   [STREAM_COUNT];
    logic [15:0] revision_mem [STREAM_COUNT];
    logic [7:0]  det_mem      [STREAM_COUNT];

    logic [STREAM_COUNT-1:0] valid_reg, valid_next;
    logic [31:0] pub_cnt_reg,   pub_cnt_next;
    logic [31:0] stale_cnt_reg, stale_cnt_next;
    logic [31:0] err_cnt_reg,   err_cnt_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg,    status_next;
    logic        read_hit_reg,  read_hit_next;
    logic [31:0] job_reg;
    logic [31:0] frame_reg;
    logic [63:0] stamp_reg;
    logic [7:0]  worker_reg;
    logic [15:0] revision_reg;
    logic [7:0]  det_reg;

    logic [IDX_W-1:0] idx;
    logic             hit;
    logic             newer;
    logic             wr_en;
    logic             inv_en;

    // take the next request once the result register is free or being drained
    assign pop = !empty && (!out_valid_reg || rsp.ready);
    assign idx = head_cmd.stream[IDX_W-1:0];
    assign hit = valid_reg[idx];

    // ordering against the stored record: later frame, or same frame and later revision
    assign newer = (head_cmd.frame > frame_mem[idx]) ||
                   ((head_cmd.frame == frame_mem[idx]) &&
                    (head_cmd.revision > revision_mem[idx]));

    // carry out the request at the head of the queue
    always_comb
    begin
        valid_next     = valid_reg;
        pub_cnt_next   = pub_cnt_reg;
        stale_cnt_next = stale_cnt_reg;
        err_cnt_next   = err_cnt_reg;
        status_next    = ltr_pkg::STATUS_BAD;
        read_hit_next  = 1'b0;
        wr_en          = 1'b0;
        inv_en         = 1'b0;
        case (head_cmd.kind)
            ltr_pkg::KIND_PUBLISH:
            begin
                if (head_cmd.bad)
                begin
                    err_cnt_next = err_cnt_reg + 1'b1;
                    status_next  = ltr_pkg::STATUS_BAD;
                end
                else if (hit && !newer)
                begin
                    stale_cnt_next = stale_cnt_reg + 1'b1;
                    status_next    = ltr_pkg::STATUS_STALE;
                end
                else
                begin
                    wr_en           = 1'b1;
                    valid_next[idx] = 1'b1;
                    pub_cnt_next    = pub_cnt_reg + 1'b1;
                    status_next     = ltr_pkg::STATUS_OK;
                end
            end
            ltr_pkg::KIND_READ:
            begin
                if (head_cmd.bad)
                begin
                    status_next = ltr_pkg::STATUS_BAD;
                end
                else if (!hit)
                begin
                    status_next = ltr_pkg::STATUS_NOT_VALID;
                end
                else
                begin
                    read_hit_next = 1'b1;
                    status_next   = ltr_pkg::STATUS_OK;
                end
            end
            ltr_pkg::KIND_INVALIDATE:
            begin
                if (head_cmd.bad)
                begin
                    status_next = ltr_pkg::STATUS_BAD;
                end
                else if (!hit)
                begin
                    status_next = ltr_pkg::STATUS_NOT_VALID;
                end
                else
                begin
                    inv_en          = 1'b1;
                    valid_next[idx] = 1'b0;
                    status_next     = ltr_pkg::STATUS_OK;
                end
            end
            default:
            begin
                status_next = ltr_pkg::STATUS_BAD;
            end
        endcase
        if (!pop)
        begin
            valid_next     = valid_reg;
            pub_cnt_next   = pub_cnt_reg;
            stale_cnt_next = stale_cnt_reg;
            err_cnt_next   = err_cnt_reg;
            wr_en          = 1'b0;
            inv_en         = 1'b0;
        end
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            pub_cnt_reg   <= '0;
            stale_cnt_reg <= '0;
            err_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ltr_pkg::STATUS_OK;
            read_hit_reg  <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            pub_cnt_reg   <= pub_cnt_next;
            stale_cnt_reg <= stale_cnt_next;
            err_cnt_reg   <= err_cnt_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                status_reg   <= status_next;
                read_hit_reg <= read_hit_next;
            end
        end
    end

    // record payload captured for a read
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg      <= job_mem[idx];
            frame_reg    <= frame_mem[idx];
            stamp_reg    <= stamp_mem[idx];
            worker_reg   <= worker_mem[idx];
            revision_reg <= revision_mem[idx];
            det_reg      <= det_mem[idx];
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            job_mem[idx]      <= head_cmd.job;
            frame_mem[idx]    <= head_cmd.frame;
            stamp_mem[idx]    <= head_cmd.stamp;
            worker_mem[idx]   <= head_cmd.worker;
            revision_mem[idx] <= head_cmd.revision;
            det_mem[idx]      <= head_cmd.detections;
        end
        else if (inv_en)
        begin
            det_mem[idx] <= '0;
        end
    end

    // result channel, record fields zero except on a successful read
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.out_job        = read_hit_reg ? job_reg      : '0;
    assign rsp.out_frame      = read_hit_reg ? frame_reg    : '0;
    assign rsp.out_stamp      = read_hit_reg ? stamp_reg    : '0;
    assign rsp.out_worker     = read_hit_reg ? worker_reg   : '0;
    assign rsp.out_revision   = read_hit_reg ? revision_reg : '0;
    assign rsp.out_detections = read_hit_reg ? det_reg      : '0;
    assign rsp.publish_total  = pub_cnt_reg;
    assign rsp.stale_total    = stale_cnt_reg;
    assign rsp.error_total    = err_cnt_reg;

endmodule
